// ===== hdl/rtffa_pkg.sv =====
`timescale 1ns / 1ps

package rtffa_pkg;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] amount;
  } item_t;

  typedef struct packed {
    logic [31:0] block_start;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       scan_from_slot;
    logic       scan_from_zero;
    logic       issue;
    logic       clear_write;
    logic       take_slot;
    logic       reserve_write;
    logic       w_clear;
    logic       w_jump;
    logic       alloc_write;
    logic       free_write;
    logic       reply;
    logic [1:0] reply_status;
    logic       reply_with_w;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       rd_valid;
    logic       rd_last;
    logic       cnt_full;
    logic       slot_free;
    logic       overlap;
    logic       start_match;
    logic       over_range;
    logic [1:0] opcode;
  } dp_stat_t;

endpackage

// ===== hdl/rtffa_ctrl.sv =====
`timescale 1ns / 1ps

module rtffa_ctrl import rtffa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_SLOT     = 3'd3;
  localparam logic [2:0] S_FIT      = 3'd4;
  localparam logic [2:0] S_FREE     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.cnt_full) begin
          state_next = S_IDLE;
        end else begin
          cmd.clear_write = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.opcode) inside
          OP_ALLOC, OP_RESERVE: begin
            cmd.scan_from_slot = 1'b1;
            state_next         = S_SLOT;
          end
          OP_FREE: begin
            cmd.scan_from_zero = 1'b1;
            state_next         = S_FREE;
          end
          default: begin
            cmd.reply        = 1'b1;
            cmd.reply_status = ST_OK;
            state_next       = S_IDLE;
          end
        endcase
      end
      S_SLOT: begin
        cmd.issue = !stat.cnt_full && !(stat.rd_valid && stat.slot_free);
        if (stat.rd_valid && stat.slot_free) begin
          if (stat.opcode == OP_ALLOC) begin
            cmd.take_slot      = 1'b1;
            cmd.w_clear        = 1'b1;
            cmd.scan_from_zero = 1'b1;
            state_next         = S_FIT;
          end else begin
            cmd.reserve_write = 1'b1;
            cmd.reply         = 1'b1;
            cmd.reply_status  = ST_OK;
            state_next        = S_IDLE;
          end
        end else if (stat.rd_valid && stat.rd_last) begin
          cmd.reply        = 1'b1;
          cmd.reply_status = ST_NO_SLOT;
          state_next       = S_IDLE;
        end
      end
      S_FIT: begin
        cmd.issue = !stat.cnt_full && !(stat.rd_valid && stat.overlap);
        if (stat.rd_valid && stat.overlap) begin
          cmd.w_jump         = 1'b1;
          cmd.scan_from_zero = 1'b1;
        end else if (stat.rd_valid && stat.rd_last) begin
          cmd.reply  = 1'b1;
          state_next = S_IDLE;
          if (stat.over_range) begin
            cmd.reply_status = ST_EXHAUSTED;
          end else begin
            cmd.alloc_write  = 1'b1;
            cmd.reply_status = ST_OK;
            cmd.reply_with_w = 1'b1;
          end
        end
      end
      S_FREE: begin
        cmd.issue      = !stat.cnt_full;
        cmd.free_write = stat.rd_valid && stat.start_match;
        if (stat.rd_valid && stat.rd_last) begin
          cmd.reply        = 1'b1;
          cmd.reply_status = ST_OK;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/rtffa_dp.sv =====
`timescale 1ns / 1ps

module rtffa_dp import rtffa_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  item_t     request,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output rsp_t      response,
  output logic      response_valid
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);

  entry_t mem [ENTRIES];

  item_t            req;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] cnt;
  logic             rd_valid;
  logic             rd_last;
  logic [IDX_W-1:0] rd_at;
  entry_t           rd_data;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] next_slot;
  logic [31:0]      w;

  logic [IDX_W-1:0] rd_idx_inc;
  logic [IDX_W-1:0] rd_at_inc;
  logic [32:0]      fit_sum;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  assign rd_idx_inc = (rd_idx == IDX_LAST) ? '0 : rd_idx + 1'b1;
  assign rd_at_inc  = (rd_at == IDX_LAST) ? '0 : rd_at + 1'b1;
  assign fit_sum    = {1'b0, w} + {1'b0, req.amount};

  assign stat.rd_valid    = rd_valid;
  assign stat.rd_last     = rd_last;
  assign stat.cnt_full    = (cnt == CNT_FULL);
  assign stat.slot_free   = (rd_data.start_addr == '0) && (rd_data.end_addr == '0);
  assign stat.overlap     = (fit_sum > {1'b0, rd_data.start_addr}) && (w < rd_data.end_addr);
  assign stat.start_match = (rd_data.start_addr == req.address);
  assign stat.over_range  = fit_sum[32];
  assign stat.opcode      = req.opcode;

  always_comb begin
    we    = 1'b0;
    waddr = rd_at;
    wdata = '0;
    if (cmd.clear_write) begin
      we    = 1'b1;
      waddr = rd_idx;
    end else if (cmd.reserve_write) begin
      we               = 1'b1;
      wdata.start_addr = req.address;
      wdata.end_addr   = req.amount;
    end else if (cmd.alloc_write) begin
      we               = 1'b1;
      waddr            = slot;
      wdata.start_addr = w;
      wdata.end_addr   = fit_sum[31:0];
    end else if (cmd.free_write) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_idx];
      rd_at   <= rd_idx;
      rd_last <= (cnt == CNT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx         <= '0;
      cnt            <= '0;
      rd_valid       <= 1'b0;
      next_slot      <= '0;
      response_valid <= 1'b0;
    end else begin
      rd_valid       <= cmd.issue;
      response_valid <= cmd.reply;
      if (cmd.scan_from_slot) begin
        rd_idx <= next_slot;
        cnt    <= '0;
      end else if (cmd.scan_from_zero) begin
        rd_idx <= '0;
        cnt    <= '0;
      end else if (cmd.issue || cmd.clear_write) begin
        rd_idx <= rd_idx_inc;
        cnt    <= cnt + 1'b1;
      end
      if (cmd.take_slot) begin
        next_slot <= rd_at;
      end else if (cmd.reserve_write) begin
        next_slot <= rd_at_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
    if (cmd.take_slot) begin
      slot <= rd_at;
    end
    if (cmd.w_clear) begin
      w <= '0;
    end else if (cmd.w_jump) begin
      w <= rd_data.end_addr;
    end
    if (cmd.reply) begin
      response.status      <= cmd.reply_status;
      response.block_start <= cmd.reply_with_w ? w : '0;
    end
  end

endmodule

// ===== hdl/range_table_first_fit_allocator.sv =====
`timescale 1ns / 1ps

// Range table allocator with a table that is read one entry per cycle. After reset the table
// is cleared by a pass of ENTRIES writes, and busy stays high until that pass is done. An item
// is taken when start is high and busy is low, and its result appears on response for exactly
// one cycle with response_valid high; the receiver cannot stall it, so it must take every
// result. An unknown opcode answers straight from dispatch, a free after a sweep of the whole
// table and a reserve after a search for a free slot. An allocate costs a slot search, then a
// first-fit sweep, one more sweep for every collision that moves the candidate start, and
// then the result.

module range_table_first_fit_allocator import rtffa_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  item_t request,
  output logic  busy,
  output rsp_t  response,
  output logic  response_valid
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rtffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rtffa_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .request        (request),
    .cmd            (cmd),
    .stat           (stat),
    .response       (response),
    .response_valid (response_valid)
  );

endmodule

// ===== hdl/rtffa_checker.sv =====
`timescale 1ns / 1ps

module rtffa_checker import rtffa_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  start,
  input logic  busy,
  input rsp_t  response,
  input logic  response_valid
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_rsp_idle: assert property (@(posedge clk) disable iff (rst)
    response_valid |-> !busy)
    else $error("result shown while still busy");

  a_rsp_single: assert property (@(posedge clk) disable iff (rst)
    response_valid |=> !response_valid)
    else $error("two results in consecutive cycles");

  a_rsp_status: assert property (@(posedge clk) disable iff (rst)
    response_valid |-> (response.status == ST_OK || response.status == ST_NO_SLOT ||
                        response.status == ST_EXHAUSTED))
    else $error("undefined result status");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (response_valid && response.status != ST_OK) |-> (response.block_start == '0))
    else $error("failed item returned a nonzero start");

endmodule

bind range_table_first_fit_allocator rtffa_checker u_rtffa_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .response       (response),
  .response_valid (response_valid)
);
